// File: rtl/core/pac_pkg.sv
// Shared types and constants for the packed ARGB pixel compositor.
`default_nettype none
package pac_pkg;

    localparam int unsigned MODE_W  = 3;
    localparam int unsigned ALPHA_W = 8;
    localparam int unsigned PIX_W   = 32;
    localparam int unsigned RCP_W   = 17;

    localparam logic [MODE_W-1:0] MODE_ARGB_OVER_ARGB = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RGB_OVER_ARGB  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ARGB_OVER_RGB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRANS_KEEP_A   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OPAQUE         = 3'd4;

    localparam logic CFG_IDX_MODE  = 1'b0;
    localparam logic CFG_IDX_ALPHA = 1'b1;

    localparam logic [PIX_W-1:0] MASK_A = 32'hFF00_0000;

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_LERP,
        KIND_CORE
    } t_kind;

endpackage
`default_nettype wire

// File: rtl/core/pac_renorm.sv
// Reciprocal lookup and color rescale by 0x10000 / final_alpha.
`default_nettype none
module pac_renorm (
    input  wire logic               i_clk,
    input  wire logic [7:0]         i_red,
    input  wire logic [7:0]         i_green,
    input  wire logic [7:0]         i_blue,
    input  wire logic [7:0]         i_fa1,
    output      pac_pkg::t_pix      o_color
);
    import pac_pkg::*;

    logic [RCP_W-1:0] w_rcp [256];

    for (genvar gi = 0; gi < 256; gi++) begin : g_rcp
        localparam logic [RCP_W-1:0] K = RCP_W'(32'h0001_0000 / (gi + 1));
        assign w_rcp[gi] = K;
    end

    logic [RCP_W-1:0] r_k;
    logic [7:0]       r_red;
    logic [7:0]       r_green;
    logic [7:0]       r_blue;
    logic [7:0]       r_fa1;

    always_ff @(posedge i_clk) begin
        r_k     <= w_rcp[i_fa1];
        r_red   <= i_red;
        r_green <= i_green;
        r_blue  <= i_blue;
        r_fa1   <= i_fa1;
    end

    logic [31:0] w_g_prod;
    logic [31:0] w_rb_prod;

    assign w_g_prod  = 32'({r_green, 8'h00}) * 32'(r_k);
    assign w_rb_prod = 32'({r_red, 8'h00, r_blue}) * 32'(r_k);

    assign o_color = {r_fa1, w_rb_prod[31:24], w_g_prod[23:16], w_rb_prod[15:8]};

endmodule
`default_nettype wire

// File: rtl/core/packed_argb_pixel_compositor.sv
// Top level of the packed ARGB pixel compositor: mode decode and blend pipeline.
//
//   channel   handshake                    payload
//   --------  ---------------------------  ------------------------------
//   config    i_cfg_we                     i_cfg_idx, i_cfg_data
//   pixel in  start && !busy               i_src_color, i_dst_color
//   pixel out o_result_valid (one cycle)   o_result_color
//
// One transaction enters every cycle; busy stays low.
// Each transaction is captured by the eff-alpha register at the edge that accepts it,
// then passes through the premultiply, lerp, reciprocal lookup and rescale registers.
// Synchronous active-low reset clears the config registers and all valid bits.
// The receiver cannot stall, so the pipeline advances every cycle.
`default_nettype none
module packed_argb_pixel_compositor (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [7:0]            i_cfg_data,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire pac_pkg::t_pix         i_src_color,
    input  wire pac_pkg::t_pix         i_dst_color,
    output      logic                  o_result_valid,
    output      pac_pkg::t_pix         o_result_color
);
    import pac_pkg::*;

    logic [MODE_W-1:0]  r_mode;
    logic [ALPHA_W-1:0] r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ARGB_OVER_ARGB;
            r_alpha <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                CFG_IDX_ALPHA: r_alpha <= i_cfg_data;
                default:       r_mode  <= r_mode;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: effective alpha
    logic [16:0] w_ea_prod;
    logic [7:0]  w_ea;

    assign w_ea_prod = 17'(i_src_color[31:24]) * 17'({1'b0, r_alpha} + 9'd1);
    assign w_ea      = (r_alpha != '0) ? w_ea_prod[15:8] : i_src_color[31:24];

    logic  r1_vld;
    t_pix  r1_src;
    t_pix  r1_dst;
    logic [7:0] r1_ea;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
        r1_src <= i_src_color;
        r1_dst <= i_dst_color;
        r1_ea  <= w_ea;
    end

    // stage 2: destination premultiply, mode decode
    logic [7:0]  w_ca;
    logic [8:0]  w_sa;
    logic [8:0]  w_da;
    logic [24:0] w_pg_prod;
    logic [32:0] w_prb_prod;
    logic [8:0]  w_lf;
    t_kind       w_kind;
    t_pix        w_res;

    assign w_ca = (r_mode == MODE_RGB_OVER_ARGB) ? r_alpha : r1_ea;
    assign w_sa = {1'b0, w_ca} + 9'd1;
    assign w_da = (r1_dst[31:24] == 8'h00) ? 9'd0 : {1'b0, r1_dst[31:24]} + 9'd1;
    assign w_pg_prod  = 25'({r1_dst[15:8], 8'h00}) * 25'(w_da);
    assign w_prb_prod = 33'({r1_dst[23:16], 8'h00, r1_dst[7:0]}) * 33'(w_da);

    always_comb begin
        w_lf   = '0;
        w_kind = KIND_PASS;
        w_res  = r1_dst;
        unique case (r_mode)
            MODE_ARGB_OVER_ARGB: begin
                if (r1_ea != 8'h00) begin
                    w_kind = KIND_CORE;
                end
            end
            MODE_RGB_OVER_ARGB: begin
                if (r_alpha == 8'h00 || r_alpha == 8'hFF) begin
                    w_res = r1_src | MASK_A;
                end else begin
                    w_kind = KIND_CORE;
                end
            end
            MODE_ARGB_OVER_RGB: begin
                w_kind = KIND_LERP;
                w_lf   = (r1_ea != 8'h00) ? {1'b0, r1_ea} + 9'd1 : 9'd0;
            end
            MODE_TRANS_KEEP_A: begin
                w_kind = KIND_LERP;
                w_lf   = (r_alpha != 8'h00) ? {1'b0, r_alpha} + 9'd1 : 9'd0;
            end
            MODE_OPAQUE: begin
                w_res = r1_src | MASK_A;
            end
            default: begin
                w_res = r1_dst;
            end
        endcase
    end

    logic        r2_vld;
    t_pix        r2_src;
    t_pix        r2_dst;
    logic [8:0]  r2_sa;
    logic [8:0]  r2_da;
    logic [15:0] r2_pg;
    logic [23:0] r2_prb;
    logic [8:0]  r2_lf;
    t_kind       r2_kind;
    t_pix        r2_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_src  <= r1_src;
        r2_dst  <= r1_dst;
        r2_sa   <= w_sa;
        r2_da   <= w_da;
        r2_pg   <= w_pg_prod[23:8];
        r2_prb  <= w_prb_prod[31:8];
        r2_lf   <= w_lf;
        r2_kind <= w_kind;
        r2_res  <= w_res;
    end

    // stage 3: lerp toward source, final alpha
    logic [31:0] w_gdiff;
    logic [31:0] w_gprod;
    logic [31:0] w_gsum;
    logic [31:0] w_rbdiff;
    logic [31:0] w_rbprod;
    logic [31:0] w_rbsum;
    logic [17:0] w_fa_prod;
    logic [9:0]  w_fa;
    logic [7:0]  w_fa1;

    assign w_gdiff  = {16'h0000, r2_src[15:8], 8'h00} - {16'h0000, r2_pg[15:8], 8'h00};
    assign w_gprod  = w_gdiff * 32'(r2_sa);
    assign w_gsum   = (w_gprod >> 8) + {16'h0000, r2_pg};
    assign w_rbdiff = {8'h00, r2_src[23:16], 8'h00, r2_src[7:0]}
                    - {8'h00, r2_prb[23:16], 8'h00, r2_prb[7:0]};
    assign w_rbprod = w_rbdiff * 32'(r2_sa);
    assign w_rbsum  = (w_rbprod >> 8) + {8'h00, r2_prb};
    assign w_fa_prod = (18'd256 - 18'(r2_sa)) * (18'd256 - 18'(r2_da));
    assign w_fa      = 10'd256 - 10'(w_fa_prod >> 8);
    assign w_fa1     = 8'(w_fa - 10'd1);

    logic [31:0] w_lgprod;
    logic [31:0] w_lg;
    logic [31:0] w_lrbprod;
    logic [31:0] w_lrb;
    logic [7:0]  w_la;
    t_pix        w_lres;

    assign w_lgprod  = ({16'h0000, r2_src[15:8], 8'h00} - {16'h0000, r2_dst[15:8], 8'h00})
                     * 32'(r2_lf);
    assign w_lg      = (w_lgprod >> 8) + {16'h0000, r2_dst[15:8], 8'h00};
    assign w_lrbprod = ({8'h00, r2_src[23:16], 8'h00, r2_src[7:0]}
                     - {8'h00, r2_dst[23:16], 8'h00, r2_dst[7:0]}) * 32'(r2_lf);
    assign w_lrb     = (w_lrbprod >> 8) + {8'h00, r2_dst[23:0]};
    assign w_la      = (r_mode == MODE_TRANS_KEEP_A) ? r2_dst[31:24] : 8'h00;
    assign w_lres    = {w_la, w_lrb[23:16], w_lg[15:8], w_lrb[7:0]};

    logic       r3_vld;
    logic       r3_core;
    t_pix       r3_res;
    logic [7:0] r3_red;
    logic [7:0] r3_green;
    logic [7:0] r3_blue;
    logic [7:0] r3_fa1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_core  <= (r2_kind == KIND_CORE);
        r3_res   <= (r2_kind == KIND_LERP) ? w_lres : r2_res;
        r3_red   <= w_rbsum[23:16];
        r3_green <= w_gsum[15:8];
        r3_blue  <= w_rbsum[7:0];
        r3_fa1   <= w_fa1;
    end

    // stages 4 and 5: reciprocal and rescale
    t_pix w_core_color;

    pac_renorm u_renorm (
        .i_clk   (i_clk),
        .i_red   (r3_red),
        .i_green (r3_green),
        .i_blue  (r3_blue),
        .i_fa1   (r3_fa1),
        .o_color (w_core_color)
    );

    logic r4_vld;
    logic r4_core;
    t_pix r4_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_core <= r3_core;
        r4_res  <= r3_res;
    end

    logic r5_vld;
    t_pix r5_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_res <= r4_core ? w_core_color : r4_res;
    end

    assign o_result_valid = r5_vld;
    assign o_result_color = r5_res;

endmodule
`default_nettype wire
